/* sv/paged_ram_cache_with_shadow_commit_top_macros.svh */
// Assertion macros for the paged RAM cache checker.
// Included by the checker file; needs no package.
`ifndef PAGED_RAM_CACHE_WITH_SHADOW_COMMIT_TOP_MACROS_SVH
`define PAGED_RAM_CACHE_WITH_SHADOW_COMMIT_TOP_MACROS_SVH
`define PRC_ASSERT_IMPL(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("assertion failed");
`define PRC_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("assertion failed");
`endif

/* sv/prc_pkg.sv */
// Shared types, codes and constants of the paged RAM cache.
// No dependencies.
package prc_pkg;
  localparam int PAGE_BITS_DEF = 5;
  localparam int RAM_PAGES_DEF = 8;
  localparam int PERSIST_PAGES_DEF = 256;
  localparam int LIST_DEPTH = 256;
  localparam int AW = 16;

  localparam logic [1:0] OP_READ = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_COMMIT = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [1:0] KIND_ADDR = 2'd0;
  localparam logic [1:0] KIND_COPY = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [1:0] REG_RAM_BASE = 2'd0;
  localparam logic [1:0] REG_STORE_BASE = 2'd1;
  localparam logic [1:0] REG_HALF_OFFSET = 2'd2;

  localparam logic [15:0] RAM_BASE_RST = 16'd7168;
  localparam logic [15:0] STORE_BASE_RST = 16'd17408;
  localparam logic [15:0] HALF_OFFSET_RST = 16'd8192;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_TAGS, ST_LIST_RD, ST_LIST_CHK, ST_VICTIM, ST_LOC_RD,
    ST_LOC_USE, ST_COMMIT_RD, ST_COMMIT_LOC, ST_COMMIT_WR, ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] src_addr;
    logic [15:0] dst_addr;
    logic        last;
  } result_t;
endpackage

/* sv/prc_ram.sv */
// Generic single-port-write, single-read synchronous RAM, registered read.
// No dependencies.
module prc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* sv/prc_out_fifo.sv */
// Four-entry result queue between the sequencer and the output channel.
// Depends on prc_pkg.
module prc_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  prc_pkg::result_t din,
  input  logic             pop,
  output prc_pkg::result_t dout,
  output logic             nonempty,
  output logic             empty
);
  prc_pkg::result_t buf_q [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  assign dout = buf_q[rp];
  assign nonempty = (cnt != 3'd0);
  assign empty = (cnt == 3'd0);
  always_ff @(posedge clk) begin
    if (push) buf_q[wp] <= din;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop) rp <= rp + 2'd1;
      cnt <= cnt + {2'b0, push} - {2'b0, pop};
    end
  end
endmodule

/* sv/prc_ctrl.sv */
// Lookup and commit sequencer: tag registers, location and shadow-list RAMs.
// Depends on prc_pkg and prc_ram.
module prc_ctrl #(
  parameter int PAGE_BITS = prc_pkg::PAGE_BITS_DEF,
  parameter int RAM_PAGES = prc_pkg::RAM_PAGES_DEF,
  parameter int PERSIST_PAGES = prc_pkg::PERSIST_PAGES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       op,
  input  logic [15:0]      addr,
  input  logic [15:0]      ram_base,
  input  logic [15:0]      store_base,
  input  logic [15:0]      half_offset,
  input  logic             q_empty,
  output logic             push,
  output prc_pkg::result_t res
);
  localparam int SW = (RAM_PAGES > 1) ? $clog2(RAM_PAGES) : 1;
  localparam int PW = (PERSIST_PAGES > 1) ? $clog2(PERSIST_PAGES) : 1;
  localparam int LW = $clog2(prc_pkg::LIST_DEPTH);
  localparam logic [15:0] OFF_MASK = 16'((1 << PAGE_BITS) - 1);

  prc_pkg::state_t state, state_next;
  logic [15:0] tags [RAM_PAGES];
  logic [RAM_PAGES-1:0] dirty;
  logic [15:0] recent_tag;
  logic [SW-1:0] recent_slot, fifo_ptr, scan;
  logic [8:0] scount, li;
  logic [1:0] cur_op;
  logic [15:0] cur_addr, cur_tag;
  logic listed, vpresent, want_bit;
  logic [7:0] want_idx, vidx;
  logic [PW-1:0] clr_cnt;
  prc_pkg::result_t r0, r1, r2;
  logic [1:0] nres, emit_i;

  logic loc_we, loc_wd, loc_rd;
  logic [PW-1:0] loc_wa, loc_ra;
  logic list_we;
  logic [LW-1:0] list_wa, list_ra;
  logic [7:0] list_wd, list_rd;

  prc_ram #(.WIDTH(1), .DEPTH(1 << PW)) u_loc (
    .clk, .we(loc_we), .waddr(loc_wa), .wdata(loc_wd), .raddr(loc_ra), .rdata(loc_rd));
  prc_ram #(.WIDTH(8), .DEPTH(prc_pkg::LIST_DEPTH)) u_list (
    .clk, .we(list_we), .waddr(list_wa), .wdata(list_wd), .raddr(list_ra),
    .rdata(list_rd));

  function automatic logic [7:0] to_idx(input logic [15:0] t, input logic [15:0] sb);
    logic [15:0] d;
    d = t - sb;
    return 8'(d >> PAGE_BITS);
  endfunction

  function automatic logic in_region(input logic [7:0] i);
    return 9'(i) < 9'(PERSIST_PAGES);
  endfunction

  function automatic logic [15:0] slot_addr(input logic [SW-1:0] s, input logic [15:0] rb);
    return rb + 16'(32'(s) << PAGE_BITS);
  endfunction

  logic [15:0] in_tag;
  logic [15:0] vtag;
  logic [7:0] cur_idx;
  assign in_tag = addr & ~OFF_MASK;
  assign vtag = tags[fifo_ptr];
  assign cur_idx = to_idx(cur_tag, store_base);

  assign in_ready = (state == prc_pkg::ST_IDLE) && q_empty;

  always_ff @(posedge clk) begin
    if (rst) state <= prc_pkg::ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    loc_we = 1'b0;
    loc_wa = clr_cnt;
    loc_wd = 1'b0;
    loc_ra = PW'(want_idx);
    list_we = 1'b0;
    list_wa = LW'(scount);
    list_wd = vidx;
    list_ra = LW'(li);
    push = 1'b0;
    res = r0;
    case (state)
      prc_pkg::ST_CLEAR: begin
        loc_we = 1'b1;
        if (clr_cnt == PW'(PERSIST_PAGES - 1)) state_next = prc_pkg::ST_IDLE;
      end
      prc_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (op == prc_pkg::OP_COMMIT) state_next = prc_pkg::ST_COMMIT_RD;
          else if (op != prc_pkg::OP_NONE && in_tag != recent_tag)
            state_next = prc_pkg::ST_TAGS;
          else if (op != prc_pkg::OP_NONE) state_next = prc_pkg::ST_EMIT;
        end
      end
      prc_pkg::ST_TAGS: begin
        if (tags[scan] == 16'd0) state_next = prc_pkg::ST_LIST_RD;
        else if (tags[scan] == cur_tag) state_next = prc_pkg::ST_EMIT;
        else if (32'(scan) == RAM_PAGES - 1) state_next = prc_pkg::ST_LIST_RD;
      end
      prc_pkg::ST_LIST_RD: begin
        if (li >= scount) state_next = prc_pkg::ST_VICTIM;
        else state_next = prc_pkg::ST_LIST_CHK;
      end
      prc_pkg::ST_LIST_CHK: state_next = prc_pkg::ST_LIST_RD;
      prc_pkg::ST_VICTIM: begin
        loc_ra = PW'(vidx);
        if (dirty[fifo_ptr] && !vpresent) list_we = 1'b1;
        state_next = prc_pkg::ST_LOC_RD;
      end
      prc_pkg::ST_LOC_RD: begin
        loc_ra = listed ? PW'(want_idx) : PW'(cur_idx);
        state_next = prc_pkg::ST_LOC_USE;
      end
      prc_pkg::ST_LOC_USE: state_next = prc_pkg::ST_EMIT;
      prc_pkg::ST_COMMIT_RD: begin
        if (li >= scount) state_next = prc_pkg::ST_EMIT;
        else state_next = prc_pkg::ST_COMMIT_LOC;
      end
      prc_pkg::ST_COMMIT_LOC: begin
        loc_ra = PW'(list_rd);
        state_next = prc_pkg::ST_COMMIT_WR;
      end
      prc_pkg::ST_COMMIT_WR: begin
        loc_wa = PW'(want_idx);
        loc_wd = ~loc_rd;
        loc_we = in_region(want_idx);
        state_next = prc_pkg::ST_COMMIT_RD;
      end
      prc_pkg::ST_EMIT: begin
        push = 1'b1;
        case (emit_i)
          2'd0: res = r0;
          2'd1: res = r1;
          default: res = r2;
        endcase
        if (emit_i + 2'd1 == nres) state_next = prc_pkg::ST_IDLE;
      end
      default: state_next = prc_pkg::ST_IDLE;
    endcase
  end

  logic [15:0] vdst;
  logic vloc;
  assign vdst = vloc ? vtag : vtag + half_offset;
  assign want_bit = (listed ? in_region(want_idx) : in_region(cur_idx)) & loc_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RAM_PAGES; i++) tags[i] <= '0;
      dirty <= '0;
      recent_tag <= '0;
      recent_slot <= '0;
      fifo_ptr <= '0;
      scount <= '0;
      clr_cnt <= '0;
    end else begin
      case (state)
        prc_pkg::ST_CLEAR: clr_cnt <= clr_cnt + PW'(1);
        prc_pkg::ST_IDLE: begin
          cur_op <= op;
          cur_addr <= addr;
          cur_tag <= in_tag;
          scan <= '0;
          li <= '0;
          listed <= 1'b0;
          vpresent <= 1'b0;
          emit_i <= '0;
          nres <= 2'd1;
          r0 <= '{prc_pkg::KIND_DONE, 16'd0, 16'd0, 1'b1};
          if (in_valid && in_ready && op != prc_pkg::OP_COMMIT &&
              op != prc_pkg::OP_NONE) begin
            if (in_tag == recent_tag) begin
              if (op == prc_pkg::OP_WRITE) dirty[recent_slot] <= 1'b1;
              r0 <= '{prc_pkg::KIND_ADDR, 16'd0,
                      slot_addr(recent_slot, ram_base) + (addr & OFF_MASK), 1'b1};
            end else recent_tag <= in_tag;
          end
        end
        prc_pkg::ST_TAGS: begin
          scan <= scan + SW'(1);
          if (tags[scan] != 16'd0 && tags[scan] == cur_tag) begin
            if (cur_op == prc_pkg::OP_WRITE) dirty[scan] <= 1'b1;
            recent_slot <= scan;
            r0 <= '{prc_pkg::KIND_ADDR, 16'd0,
                    slot_addr(scan, ram_base) + (cur_addr & OFF_MASK), 1'b1};
          end
          vidx <= to_idx(vtag, store_base);
        end
        prc_pkg::ST_LIST_RD: ;
        prc_pkg::ST_LIST_CHK: begin
          li <= li + 9'd1;
          if (!listed && 16'((32'(list_rd) << PAGE_BITS)) + store_base == cur_tag) begin
            listed <= 1'b1;
            want_idx <= list_rd;
          end
          if (list_rd == vidx) vpresent <= 1'b1;
        end
        prc_pkg::ST_VICTIM: begin
          if (dirty[fifo_ptr] && !vpresent) scount <= scount + 9'd1;
        end
        prc_pkg::ST_LOC_RD: begin
          vloc <= in_region(vidx) & loc_rd;
        end
        prc_pkg::ST_LOC_USE: begin
          if (dirty[fifo_ptr]) begin
            r0 <= '{prc_pkg::KIND_COPY, slot_addr(fifo_ptr, ram_base), vdst, 1'b0};
            r1 <= '{prc_pkg::KIND_COPY,
                    (listed ? !want_bit : want_bit) ? cur_tag + half_offset : cur_tag,
                    slot_addr(fifo_ptr, ram_base), 1'b0};
            r2 <= '{prc_pkg::KIND_ADDR, 16'd0,
                    slot_addr(fifo_ptr, ram_base) + (cur_addr & OFF_MASK), 1'b1};
            nres <= 2'd3;
          end else begin
            r0 <= '{prc_pkg::KIND_COPY,
                    (listed ? !want_bit : want_bit) ? cur_tag + half_offset : cur_tag,
                    slot_addr(fifo_ptr, ram_base), 1'b0};
            r1 <= '{prc_pkg::KIND_ADDR, 16'd0,
                    slot_addr(fifo_ptr, ram_base) + (cur_addr & OFF_MASK), 1'b1};
            nres <= 2'd2;
          end
          tags[fifo_ptr] <= cur_tag;
          dirty[fifo_ptr] <= (cur_op == prc_pkg::OP_WRITE);
          recent_slot <= fifo_ptr;
          fifo_ptr <= (32'(fifo_ptr) + 1 >= RAM_PAGES) ? '0 : fifo_ptr + SW'(1);
        end
        prc_pkg::ST_COMMIT_RD: begin
          if (li >= scount) scount <= '0;
        end
        prc_pkg::ST_COMMIT_LOC: begin
          want_idx <= list_rd;
          li <= li + 9'd1;
        end
        prc_pkg::ST_COMMIT_WR: ;
        prc_pkg::ST_EMIT: emit_i <= emit_i + 2'd1;
        default: ;
      endcase
    end
  end
endmodule

/* sv/paged_ram_cache_with_shadow_commit_top.sv */
// Top level of the paged RAM cache with shadow commit.
// Depends on prc_pkg, prc_ctrl, prc_out_fifo and prc_ram.
//
// Usage: requests enter on s_axis (tdata = op, addr); results leave on
// m_axis (tdata = src_addr, dst_addr; tuser = kind; tlast = final result).
// Registers ram_base, store_base, half_offset are written through cfg_we,
// cfg_index, cfg_data; the user must do so only while the block is idle,
// which the block itself does not enforce. A hit on the recent page is
// answered straight from idle; otherwise the tag registers are compared
// one at a time until a hit, an empty tag or the last one. A miss then
// reads and checks each shadow-list RAM entry in turn, then reads the
// location-bit RAM and emits two or three results. Commit reads and
// rewrites one location bit per list entry. The single read port of each
// memory is why these steps run one after another.
// Results queue in a small FIFO; a new request is taken only once the FIFO
// has drained, so a stalled receiver holds off s_axis_tready.
// After reset the location-bit RAM is cleared, one entry a cycle, through
// all PERSIST_PAGES entries; no request is taken meanwhile.
module paged_ram_cache_with_shadow_commit_top #(
  parameter int PAGE_BITS = prc_pkg::PAGE_BITS_DEF,
  parameter int RAM_PAGES = prc_pkg::RAM_PAGES_DEF,
  parameter int PERSIST_PAGES = prc_pkg::PERSIST_PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // op[1:0], addr[17:2], zero
  input  logic        m_axis_tready,
  output logic        m_axis_tvalid,
  output logic [31:0] m_axis_tdata,   // src_addr[15:0], dst_addr[31:16]
  output logic [1:0]  m_axis_tuser,   // kind[1:0]
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  logic [15:0] ram_base, store_base, half_offset;
  logic push, q_empty, pop;
  prc_pkg::result_t res, q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_base <= prc_pkg::RAM_BASE_RST;
      store_base <= prc_pkg::STORE_BASE_RST;
      half_offset <= prc_pkg::HALF_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        prc_pkg::REG_RAM_BASE: ram_base <= cfg_data;
        prc_pkg::REG_STORE_BASE: store_base <= cfg_data;
        prc_pkg::REG_HALF_OFFSET: half_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  prc_ctrl #(.PAGE_BITS(PAGE_BITS), .RAM_PAGES(RAM_PAGES),
             .PERSIST_PAGES(PERSIST_PAGES)) u_ctrl (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .op(s_axis_tdata[1:0]), .addr(s_axis_tdata[17:2]),
    .ram_base, .store_base, .half_offset, .q_empty, .push, .res);

  assign pop = m_axis_tvalid & m_axis_tready;

  prc_out_fifo u_fifo (
    .clk, .rst, .push, .din(res), .pop, .dout(q_out),
    .nonempty(m_axis_tvalid), .empty(q_empty));

  assign m_axis_tdata = {q_out.dst_addr, q_out.src_addr};
  assign m_axis_tuser = q_out.kind;
  assign m_axis_tlast = q_out.last;
endmodule

/* sv/prc_checker.sv */
// Port-level checker for the paged RAM cache, bound to the top level.
// Depends on prc_pkg and the assertion macro header.
`include "paged_ram_cache_with_shadow_commit_top_macros.svh"
module prc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast,
  input logic [31:0] m_axis_tdata
);
  logic kind_ok, is_done, is_addr;
  assign kind_ok = (m_axis_tuser == prc_pkg::KIND_ADDR) ||
                   (m_axis_tuser == prc_pkg::KIND_COPY) ||
                   (m_axis_tuser == prc_pkg::KIND_DONE);
  assign is_done = m_axis_tvalid && (m_axis_tuser == prc_pkg::KIND_DONE);
  assign is_addr = m_axis_tvalid && (m_axis_tuser == prc_pkg::KIND_ADDR);

  `PRC_ASSERT_IMPL(no_kind3, m_axis_tvalid, kind_ok)
  `PRC_ASSERT_IMPL(done_last, is_done, m_axis_tlast && m_axis_tdata == 32'd0)
  `PRC_ASSERT_IMPL(addr_last, is_addr, m_axis_tlast && m_axis_tdata[15:0] == 16'd0)
  `PRC_ASSERT_IMPL(ready_idle, s_axis_tready, !m_axis_tvalid)
  `PRC_ASSERT_NEXT(hold_out, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind paged_ram_cache_with_shadow_commit_top prc_checker u_prc_checker (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tuser, .m_axis_tlast, .m_axis_tdata);

/* test/tb.sv */
// Self-checking testbench for paged_ram_cache_with_shadow_commit_top.
// Needs prc_pkg and the RTL; predicts every result and compares on m_axis.
module tb;
  typedef struct {
    logic [1:0]  op;
    logic [15:0] addr;
  } access_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tready = 1'b0;
  logic        m_axis_tvalid;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  paged_ram_cache_with_shadow_commit_top DUT (.*);

  always #10 clk = ~clk;

  // predictor state
  logic [15:0] pg_ram_base, pg_store_base, pg_half;
  logic [15:0] pg_tags [8];
  bit          pg_dirty [8];
  logic [15:0] pg_recent_tag;
  int          pg_recent_slot, pg_fifo_ptr;
  bit          pg_loc [256];
  logic [7:0]  pg_shadow [256];
  int          pg_shadow_cnt;

  access_t access_q[$];
  access_t cur_access;
  prc_pkg::result_t pending_results[$];
  int      errors = 0;
  bit      calm = 0;
  int      hold_start = 0;
  int      hold_left = 0;
  logic    stall = 1'b0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic logic [15:0] slot_base(input int slot);
    return pg_ram_base + 16'(slot * 32);
  endfunction

  function automatic logic [7:0] page_index(input logic [15:0] tag);
    logic [15:0] d;
    d = tag - pg_store_base;
    return d[12:5];
  endfunction

  function automatic logic [15:0] index_addr(input logic [7:0] idx);
    return {3'b0, idx, 5'b0} + pg_store_base;
  endfunction

  function automatic void add_result(input logic [1:0] kind, input logic [15:0] src,
                                     input logic [15:0] dst);
    prc_pkg::result_t r;
    r.kind = kind;
    r.src_addr = src;
    r.dst_addr = dst;
    r.last = 1'b0;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_access(input logic [1:0] op, input logic [15:0] addr);
    logic [15:0] tag, off, src, vtag, vdst;
    logic [7:0]  want_idx, vidx;
    bit          wr, listed, present;
    int          slot;
    tag = {addr[15:5], 5'b0};
    off = {11'b0, addr[4:0]};
    wr = (op == prc_pkg::OP_WRITE);
    if (op == prc_pkg::OP_NONE) return;
    if (op == prc_pkg::OP_COMMIT) begin
      for (int i = 0; i < pg_shadow_cnt; i++) pg_loc[pg_shadow[i]] = !pg_loc[pg_shadow[i]];
      pg_shadow_cnt = 0;
      add_result(prc_pkg::KIND_DONE, 16'h0, 16'h0);
      pending_results[pending_results.size()-1].last = 1'b1;
      return;
    end
    if (tag == pg_recent_tag) begin
      if (wr) pg_dirty[pg_recent_slot] = 1;
      add_result(prc_pkg::KIND_ADDR, 16'h0, slot_base(pg_recent_slot) + off);
      pending_results[pending_results.size()-1].last = 1'b1;
      return;
    end
    pg_recent_tag = tag;
    for (int i = 0; i < 8; i++) begin
      if (pg_tags[i] == 16'h0) break;
      if (pg_tags[i] == tag) begin
        if (wr) pg_dirty[i] = 1;
        pg_recent_slot = i;
        add_result(prc_pkg::KIND_ADDR, 16'h0, slot_base(i) + off);
        pending_results[pending_results.size()-1].last = 1'b1;
        return;
      end
    end
    slot = pg_fifo_ptr;
    listed = 0;
    want_idx = '0;
    for (int i = 0; i < pg_shadow_cnt; i++) begin
      if (index_addr(pg_shadow[i]) == tag) begin
        listed = 1;
        want_idx = pg_shadow[i];
        break;
      end
    end
    if (pg_dirty[slot]) begin
      vtag = pg_tags[slot];
      vidx = page_index(vtag);
      vdst = pg_loc[vidx] ? vtag : vtag + pg_half;
      add_result(prc_pkg::KIND_COPY, slot_base(slot), vdst);
      present = 0;
      for (int i = 0; i < pg_shadow_cnt; i++)
        if (pg_shadow[i] == vidx) present = 1;
      if (!present && pg_shadow_cnt < 256) begin
        pg_shadow[pg_shadow_cnt] = vidx;
        pg_shadow_cnt++;
      end
      pg_dirty[slot] = 0;
    end
    if (listed) src = pg_loc[want_idx] ? tag : tag + pg_half;
    else src = pg_loc[page_index(tag)] ? tag + pg_half : tag;
    add_result(prc_pkg::KIND_COPY, src, slot_base(slot));
    pg_tags[slot] = tag;
    if (wr) pg_dirty[slot] = 1;
    pg_recent_slot = slot;
    pg_fifo_ptr = (slot + 1 >= 8) ? 0 : slot + 1;
    add_result(prc_pkg::KIND_ADDR, 16'h0, slot_base(slot) + off);
    pending_results[pending_results.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) predict_access(cur_access.op, cur_access.addr);
      if (access_q.size() > 0 && (calm || $urandom_range(99) >= 16)) begin
        cur_access = access_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, cur_access.addr, cur_access.op};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // count down a long receiver hold-off
  always @(posedge clk) begin
    if (hold_start != 0) begin
      hold_left = hold_start;
      hold_start = 0;
    end
    if (hold_left > 0) hold_left--;
    stall <= (hold_left > 0);
  end

  always @(posedge clk) begin
    prc_pkg::result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          report($sformatf("unexpected result kind %0d", m_axis_tuser));
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tuser !== want.kind)
            report($sformatf("kind %0d, want %0d", m_axis_tuser, want.kind));
          if (m_axis_tdata[15:0] !== want.src_addr)
            report($sformatf("src %h, want %h", m_axis_tdata[15:0], want.src_addr));
          if (m_axis_tdata[31:16] !== want.dst_addr)
            report($sformatf("dst %h, want %h", m_axis_tdata[31:16], want.dst_addr));
          if (m_axis_tlast !== want.last)
            report($sformatf("last %b, want %b", m_axis_tlast, want.last));
        end
      end
      if (stall) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 16);
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      prc_pkg::REG_RAM_BASE: pg_ram_base = val;
      prc_pkg::REG_STORE_BASE: pg_store_base = val;
      default: pg_half = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    while (access_q.size() > 0 || s_axis_tvalid || pending_results.size() > 0)
      @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  function automatic access_t pick_access(input logic [15:0] pool_base);
    access_t a;
    int      r;
    r = $urandom_range(99);
    a.op = (r < 48) ? prc_pkg::OP_READ : (r < 88) ? prc_pkg::OP_WRITE :
           (r < 97) ? prc_pkg::OP_COMMIT : prc_pkg::OP_NONE;
    if ($urandom_range(99) < 8) a.addr = 16'($urandom);
    else a.addr = pool_base + 16'($urandom_range(11) * 32 + $urandom_range(31));
    return a;
  endfunction

  task automatic run_phase(input logic [15:0] rb, input logic [15:0] sb,
                           input logic [15:0] ho, input int count, input bit directed);
    logic [15:0] pool;
    access_t     a;
    write_reg(prc_pkg::REG_RAM_BASE, rb);
    write_reg(prc_pkg::REG_STORE_BASE, sb);
    write_reg(prc_pkg::REG_HALF_OFFSET, ho);
    pool = {sb[15:5], 5'b0};
    if (directed) begin
      access_q.push_back('{prc_pkg::OP_READ, 16'h0000});
      access_q.push_back('{prc_pkg::OP_WRITE, 16'h001F});
      access_q.push_back('{prc_pkg::OP_NONE, 16'hFFFF});
      access_q.push_back('{prc_pkg::OP_COMMIT, 16'h0000});
      access_q.push_back('{prc_pkg::OP_WRITE, 16'hFFFF});
      for (int i = 0; i < 9; i++)
        access_q.push_back('{prc_pkg::OP_WRITE, pool + 16'(i * 32 + i)});
      access_q.push_back('{prc_pkg::OP_READ, pool + 16'd32});
      access_q.push_back('{prc_pkg::OP_READ, pool + 16'd64});
      access_q.push_back('{prc_pkg::OP_COMMIT, 16'h1234});
      access_q.push_back('{prc_pkg::OP_READ, pool});
      access_q.push_back('{prc_pkg::OP_READ, 16'hFFE0});
      access_q.push_back('{prc_pkg::OP_WRITE, pool + 16'd33});
      for (int i = 9; i < 12; i++)
        access_q.push_back('{prc_pkg::OP_READ, pool + 16'(i * 32 + 31)});
      access_q.push_back('{prc_pkg::OP_COMMIT, 16'hFFFF});
      access_q.push_back('{prc_pkg::OP_READ, pool + 16'd96});
      access_q.push_back('{prc_pkg::OP_READ, 16'h0000});
    end
    for (int i = 0; i < count; i++) begin
      a = pick_access(pool);
      access_q.push_back(a);
    end
  endtask

  initial begin
    pg_ram_base = prc_pkg::RAM_BASE_RST;
    pg_store_base = prc_pkg::STORE_BASE_RST;
    pg_half = prc_pkg::HALF_OFFSET_RST;
    foreach (pg_tags[i]) begin
      pg_tags[i] = '0;
      pg_dirty[i] = 0;
    end
    foreach (pg_loc[i]) pg_loc[i] = 0;
    pg_recent_tag = '0;
    pg_recent_slot = 0;
    pg_fifo_ptr = 0;
    pg_shadow_cnt = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    run_phase(prc_pkg::RAM_BASE_RST, prc_pkg::STORE_BASE_RST, prc_pkg::HALF_OFFSET_RST,
              95, 1);
    hold_start = 400;
    drain();
    calm = 1;
    run_phase(16'h0000, 16'h0000, 16'h0000, 60, 0);
    drain();
    calm = 0;
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 60, 0);
    drain();
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), 70, 0);
    drain();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
